// ===== rtl/bavs_pkg.sv =====
// shared types and codes for the bank aware dirty victim select block
package bavs_pkg;

	localparam logic [1:0] CMD_WRITEBACK = 2'd0;
	localparam logic [1:0] CMD_VICTIM    = 2'd1;
	localparam logic [1:0] CMD_EAGER     = 2'd2;
	localparam logic [1:0] CMD_NONE      = 2'd3;

	localparam logic [1:0] MODE_STEER      = 2'd0;
	localparam logic [1:0] MODE_CLEAN_ONLY = 2'd1;
	localparam logic [1:0] MODE_EVICT_ONLY = 2'd2;

	localparam logic REG_POLICY_MODE     = 1'b0;
	localparam logic REG_PREFER_LOWER    = 1'b1;

	localparam logic KIND_ACK      = 1'b0;
	localparam logic KIND_DECISION = 1'b1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              in_range;
		logic [1:0]        channel;
		logic [3:0]        bank;
		logic              dirty;
		logic [3:0]        position;
		logic signed [4:0] initial_way;
		logic              first;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       prefer_lower;
	} cfg_t;

endpackage

// ===== rtl/bavs_front.sv =====
// input side: unpacks and classifies beats, drops unused commands
module bavs_front #(
	parameter int CHANNELS          = 4,
	parameter int BANKS_PER_CHANNEL = 16
) (
	input  logic                 in_valid,
	input  logic [23:0]          in_data,
	input  logic [1:0]           in_user,
	input  logic                 in_last,
	input  logic                 queue_ready,
	output logic                 in_ready,
	output logic                 push,
	output bavs_pkg::item_t      item
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BK_W = $clog2(BANKS_PER_CHANNEL);

	logic [CH_W+1:0] ch_wide;
	logic [BK_W+3:0] bk_wide;
	logic            ch_ok;
	logic            bk_ok;

	assign ch_wide = {{CH_W{1'b0}}, in_data[1:0]};
	assign bk_wide = {{BK_W{1'b0}}, in_data[5:2]};
	assign ch_ok   = ch_wide < (CH_W+2)'(CHANNELS);
	assign bk_ok   = bk_wide < (BK_W+4)'(BANKS_PER_CHANNEL);

	assign in_ready = queue_ready;
	assign push     = in_valid && queue_ready && (in_user != bavs_pkg::CMD_NONE);

	always_comb begin
		item.cmd         = in_user;
		item.in_range    = ch_ok && bk_ok;
		item.channel     = in_data[1:0];
		item.bank        = in_data[5:2];
		item.dirty       = in_data[6];
		item.position    = in_data[10:7];
		item.initial_way = $signed(in_data[15:11]);
		item.first       = in_data[16];
		item.last        = in_last;
	end

endmodule

// ===== rtl/bavs_queue.sv =====
// two entry queue between the classifying front and the executing back
module bavs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bavs_pkg::item_t push_item,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output bavs_pkg::item_t head
);

	localparam int DEPTH = 2;

	bavs_pkg::item_t entry_q [DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign not_full  = count_q != 2'(DEPTH);
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/bavs_back.sv =====
// executing side: bank bit tracking, scan selection and the result register
module bavs_back #(
	parameter int CHANNELS          = 4,
	parameter int BANKS_PER_CHANNEL = 16,
	parameter int WAYS              = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bavs_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  bavs_pkg::item_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_kind,
	output logic [4:0]      out_way,
	output logic            out_steered,
	output logic            out_sync
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BK_W  = $clog2(BANKS_PER_CHANNEL);
	localparam int CNT_W = $clog2(WAYS + 1);
	localparam int WAY_W = $clog2(WAYS);
	localparam int MW    = (CNT_W > 4) ? CNT_W : 4;

	logic [BANKS_PER_CHANNEL-1:0] bits_q [CHANNELS];
	logic [CNT_W-1:0]             way_cnt_q;
	logic signed [4:0]            held_way_q;
	logic                         init_dirty_q;
	logic                         init_free_q;
	logic                         best_found_q;
	logic [WAY_W-1:0]             best_way_q;
	logic [3:0]                   best_pos_q;

	logic                         out_valid_q;
	logic                         out_kind_q;
	logic [4:0]                   out_way_q;
	logic                         out_steer_q;
	logic                         out_sync_q;

	logic [CH_W+1:0]              ch_wide;
	logic [BK_W+3:0]              bk_wide;
	logic [CH_W-1:0]              ch_idx;
	logic [BK_W-1:0]              bk_idx;
	logic [BANKS_PER_CHANNEL-1:0] row;
	logic [BANKS_PER_CHANNEL-1:0] row_set;
	logic [BANKS_PER_CHANNEL-1:0] row_next;
	logic                         bit_set;
	logic                         is_wb;
	logic                         bank_free;

	logic [CNT_W-1:0]             cnt;
	logic signed [4:0]            held;
	logic                         idirty;
	logic                         ifree;
	logic                         bfound;
	logic [WAY_W-1:0]             bway;
	logic [3:0]                   bpos;
	logic                         in_ways;
	logic                         match;
	logic                         better;
	logic                         take;
	logic [CNT_W-1:0]             cnt_next;
	logic                         idirty_next;
	logic                         ifree_next;
	logic                         bfound_next;
	logic [WAY_W-1:0]             bway_next;
	logic [3:0]                   bpos_next;

	logic                         emit;
	logic                         r_kind;
	logic [4:0]                   r_way;
	logic                         r_steer;
	logic                         r_sync;

	assign pop         = head_valid && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_way     = out_way_q;
	assign out_steered = out_steer_q;
	assign out_sync    = out_sync_q;

	assign ch_wide   = {{CH_W{1'b0}}, head.channel};
	assign bk_wide   = {{BK_W{1'b0}}, head.bank};
	assign ch_idx    = ch_wide[CH_W-1:0];
	assign bk_idx    = bk_wide[BK_W-1:0];
	assign row       = bits_q[ch_idx];
	assign bit_set   = row[bk_idx];
	assign bank_free = head.in_range && !bit_set;
	assign is_wb     = head.cmd == bavs_pkg::CMD_WRITEBACK;

	always_comb begin
		row_set         = row;
		row_set[bk_idx] = 1'b1;
		row_next        = (&row_set) ? '0 : row_set;
	end

	// scan step
	always_comb begin
		cnt    = head.first ? '0 : way_cnt_q;
		held   = head.first ? head.initial_way : held_way_q;
		idirty = head.first ? 1'b0 : init_dirty_q;
		ifree  = head.first ? 1'b0 : init_free_q;
		bfound = head.first ? 1'b0 : best_found_q;
		bway   = head.first ? '0 : best_way_q;
		bpos   = head.first ? 4'd0 : best_pos_q;

		in_ways = cnt < CNT_W'(WAYS);
		match   = !held[4] && (MW'(cnt) == MW'(held[3:0]));
		better  = cfg.prefer_lower ? (head.position < bpos) : (head.position > bpos);
		take    = in_ways && head.dirty && bank_free && (!bfound || better);

		cnt_next    = in_ways ? cnt + CNT_W'(1) : cnt;
		idirty_next = (in_ways && match) ? head.dirty : idirty;
		ifree_next  = (in_ways && match) ? bank_free : ifree;
		bfound_next = bfound || take;
		bway_next   = take ? cnt[WAY_W-1:0] : bway;
		bpos_next   = take ? head.position : bpos;
	end

	// result for the beat at the head
	always_comb begin
		emit    = is_wb || head.last;
		r_kind  = bavs_pkg::KIND_DECISION;
		r_way   = 5'h1f;
		r_steer = 1'b0;
		r_sync  = 1'b0;
		if (is_wb) begin
			r_kind = bavs_pkg::KIND_ACK;
			r_sync = bank_free;
		end else if (head.cmd == bavs_pkg::CMD_VICTIM) begin
			if (cfg.mode == bavs_pkg::MODE_CLEAN_ONLY) begin
				r_way = held;
			end else if (!held[4] && (!idirty_next || ifree_next)) begin
				r_way = held;
			end else if (bfound_next) begin
				r_way   = 5'(bway_next);
				r_steer = 1'b1;
			end else begin
				r_way = held;
			end
		end else begin
			if (cfg.mode != bavs_pkg::MODE_EVICT_ONLY && bfound_next) begin
				r_way   = 5'(bway_next);
				r_steer = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				bits_q[c] <= '0;
			end
			way_cnt_q    <= '0;
			held_way_q   <= -5'sd1;
			init_dirty_q <= 1'b0;
			init_free_q  <= 1'b0;
			best_found_q <= 1'b0;
			best_way_q   <= '0;
			best_pos_q   <= 4'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && is_wb && head.in_range) begin
				bits_q[ch_idx] <= row_next;
			end
			if (pop && !is_wb) begin
				way_cnt_q    <= cnt_next;
				held_way_q   <= held;
				init_dirty_q <= idirty_next;
				init_free_q  <= ifree_next;
				best_found_q <= bfound_next;
				best_way_q   <= bway_next;
				best_pos_q   <= bpos_next;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_kind_q  <= r_kind;
			out_way_q   <= r_way;
			out_steer_q <= r_steer;
			out_sync_q  <= r_sync;
		end
	end

endmodule

// ===== rtl/bank_aware_dirty_victim_select.sv =====
// top level of the bank aware dirty victim select block
// Takes one beat per cycle, sustained, while the result side is not stalled; a
// beat is registered in the two entry queue and its result in the output
// register. A single back end stage reads and updates one channel's written-bank
// bits and the running best candidate in each cycle, which sets the rate of one
// beat per cycle; the queue separates it from the input side. Writeback beats
// always answer; scan beats answer only on the beat marked last.
module bank_aware_dirty_victim_select #(
	parameter int CHANNELS          = 4,
	parameter int BANKS_PER_CHANNEL = 16,
	parameter int WAYS              = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// channel, bank, dirty, position, initial_way, first_of_set, zero pad
	input  logic [23:0] s_tdata,
	// cmd
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// chosen_way, steered, sync_needed, zero pad
	output logic [7:0]  m_tdata,
	// result_kind
	output logic        m_tuser
);

	bavs_pkg::cfg_t  cfg_q;
	bavs_pkg::item_t front_item;
	bavs_pkg::item_t head_item;
	logic            push;
	logic            queue_not_full;
	logic            queue_not_empty;
	logic            pop;
	logic [4:0]      res_way;
	logic            res_steered;
	logic            res_sync;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= bavs_pkg::MODE_STEER;
			cfg_q.prefer_lower <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bavs_pkg::REG_POLICY_MODE:  cfg_q.mode         <= cfg_data;
				bavs_pkg::REG_PREFER_LOWER: cfg_q.prefer_lower <= cfg_data[0];
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	bavs_front #(
		.CHANNELS          (CHANNELS),
		.BANKS_PER_CHANNEL (BANKS_PER_CHANNEL)
	) u_front (
		.in_valid    (s_tvalid),
		.in_data     (s_tdata),
		.in_user     (s_tuser),
		.in_last     (s_tlast),
		.queue_ready (queue_not_full),
		.in_ready    (s_tready),
		.push        (push),
		.item        (front_item)
	);

	bavs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.not_full  (queue_not_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.head      (head_item)
	);

	bavs_back #(
		.CHANNELS          (CHANNELS),
		.BANKS_PER_CHANNEL (BANKS_PER_CHANNEL),
		.WAYS              (WAYS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (queue_not_empty),
		.head        (head_item),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_way     (res_way),
		.out_steered (res_steered),
		.out_sync    (res_sync)
	);

	assign m_tdata = {1'b0, res_sync, res_steered, res_way};

endmodule

// ===== dv/victim_select_checker.sv =====
// beat monitor, victim select predictor and result comparison for the testbench
module victim_select_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// channel, bank, dirty, position, initial_way, first_of_set, zero pad
	input  logic [23:0] s_tdata,
	// cmd
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// chosen_way, steered, sync_needed, zero pad
	input  logic [7:0]  m_tdata,
	// result_kind
	input  logic        m_tuser,
	output int          mismatches,
	output int          awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNEL_COUNT = 4;
	localparam int WAY_COUNT     = 16;

	typedef struct packed {
		logic              kind;
		logic signed [4:0] way;
		logic              steered;
		logic              sync;
	} answer_t;

	answer_t           expected_answers [$];
	answer_t           want;
	logic [15:0]       written_bits [CHANNEL_COUNT];
	logic [4:0]        way_count;
	logic signed [4:0] held_initial;
	logic              initial_dirty;
	logic              initial_free;
	logic              best_found;
	logic [3:0]        best_way;
	logic [3:0]        best_pos;
	logic [1:0]        mode;
	logic              prefer_lower;
	int                fail_count = 0;

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		fail_count++;
		$display("[%0t] %s mismatch: got %0d expected %0d", $realtime, what, got_v, want_v);
	endtask

	task automatic predict_answer(input logic [1:0] cmd, input logic [1:0] ch,
		input logic [3:0] bk, input logic dirty, input logic [3:0] pos,
		input logic signed [4:0] iw, input logic first, input logic last);
		logic    free_bank;
		logic    better;
		answer_t ans;
		if (cmd == bavs_pkg::CMD_NONE)
			return;
		ans.kind = bavs_pkg::KIND_DECISION;
		ans.way = '1;
		ans.steered = 1'b0;
		ans.sync = 1'b0;
		if (cmd == bavs_pkg::CMD_WRITEBACK) begin
			ans.kind = bavs_pkg::KIND_ACK;
			ans.sync = !written_bits[ch][bk];
			written_bits[ch][bk] = 1'b1;
			// every bank written, start over
			if (&written_bits[ch])
				written_bits[ch] = '0;
			expected_answers.push_back(ans);
			return;
		end
		if (first) begin
			way_count = '0;
			held_initial = iw;
			initial_dirty = 1'b0;
			initial_free = 1'b0;
			best_found = 1'b0;
			best_way = '0;
			best_pos = '0;
		end
		if (way_count < WAY_COUNT) begin
			free_bank = !written_bits[ch][bk];
			if (int'(way_count) == int'(held_initial)) begin
				initial_dirty = dirty;
				initial_free = free_bank;
			end
			better = prefer_lower ? (pos < best_pos) : (pos > best_pos);
			if (dirty && free_bank && (!best_found || better)) begin
				best_found = 1'b1;
				best_way = way_count[3:0];
				best_pos = pos;
			end
			way_count++;
		end
		if (!last)
			return;
		if (cmd == bavs_pkg::CMD_VICTIM) begin
			if (mode != bavs_pkg::MODE_CLEAN_ONLY && best_found
					&& !(!held_initial[4] && (!initial_dirty || initial_free))) begin
				ans.way = {1'b0, best_way};
				ans.steered = 1'b1;
			end else begin
				ans.way = held_initial;
			end
		end else if (mode != bavs_pkg::MODE_EVICT_ONLY && best_found) begin
			ans.way = {1'b0, best_way};
			ans.steered = 1'b1;
		end
		expected_answers.push_back(ans);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (written_bits[c])
				written_bits[c] = '0;
			way_count = '0;
			held_initial = '1;
			initial_dirty = 1'b0;
			initial_free = 1'b0;
			best_found = 1'b0;
			best_way = '0;
			best_pos = '0;
			mode = bavs_pkg::MODE_STEER;
			prefer_lower = 1'b0;
			expected_answers.delete();
			awaiting <= 0;
			mismatches <= fail_count;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("unexpected result beat, chosen_way",
						$signed(m_tdata[4:0]), 0);
				end else begin
					want = expected_answers.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("result_kind", m_tuser, want.kind);
					if (m_tdata[4:0] !== want.way)
						report_mismatch("chosen_way", $signed(m_tdata[4:0]), want.way);
					if (m_tdata[5] !== want.steered)
						report_mismatch("steered", m_tdata[5], want.steered);
					if (m_tdata[6] !== want.sync)
						report_mismatch("sync_needed", m_tdata[6], want.sync);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bavs_pkg::REG_POLICY_MODE)
					mode = cfg_data;
				else
					prefer_lower = cfg_data[0];
			end
			if (s_tvalid && s_tready)
				predict_answer(s_tuser, s_tdata[1:0], s_tdata[5:2], s_tdata[6], s_tdata[10:7],
					s_tdata[15:11], s_tdata[16], s_tlast);
			awaiting <= expected_answers.size();
			mismatches <= fail_count;
		end
	end

endmodule

// ===== dv/testbench.sv =====
// top of the testbench: clock, reset, writeback and scan stimulus, verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_ALIAS_STEER = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 235;
	localparam int HOLD_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [1:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	int          mismatches;
	int          awaiting;
	int          src_idle_pct = 20;
	int          sink_idle_pct = 20;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int          hold_left = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	logic [1:0]  mode_plan [PHASES] = '{bavs_pkg::MODE_STEER, bavs_pkg::MODE_CLEAN_ONLY,
		bavs_pkg::MODE_EVICT_ONLY, MODE_ALIAS_STEER, bavs_pkg::MODE_STEER,
		bavs_pkg::MODE_EVICT_ONLY, bavs_pkg::MODE_CLEAN_ONLY, bavs_pkg::MODE_STEER};
	logic        lower_plan [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

	bank_aware_dirty_victim_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	victim_select_checker answer_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_beat(input logic [1:0] cmd, input logic [1:0] ch, input logic [3:0] bk,
		input logic dirty, input logic [3:0] pos, input logic [4:0] iw, input logic first,
		input logic last);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tlast <= last;
		s_tdata <= {7'd0, first, iw, pos, dirty, bk, ch};
		do @(posedge clk); while (!s_tready);
		if (cmd != bavs_pkg::CMD_NONE)
			items_sent++;
	endtask

	task automatic send_writeback(input logic [1:0] ch, input logic [3:0] bk);
		send_beat(bavs_pkg::CMD_WRITEBACK, ch, bk, 1'($urandom_range(1)),
			4'($urandom_range(15)), 5'($urandom_range(31)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	task automatic run_scan(input logic [1:0] cmd);
		int         ways;
		int         pick;
		logic [4:0] iw;
		logic       with_first;
		ways = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
		pick = $urandom_range(99);
		if (pick < 60)
			iw = 5'($urandom_range((ways > 16) ? 15 : ways - 1));
		else if (pick < 75)
			iw = '1;
		else
			iw = 5'($urandom_range(31));
		// now and then a scan arrives without its first beat
		with_first = ($urandom_range(19) != 0);
		for (int w = 0; w < ways; w++) begin
			if ($urandom_range(9) == 0)
				send_writeback(2'($urandom_range(3)), 4'($urandom_range(15)));
			send_beat(cmd, 2'($urandom_range(3)), 4'($urandom_range(15)), $urandom_range(4) < 3,
				4'($urandom_range(15)), (w == 0) ? iw : 5'($urandom_range(31)),
				(w == 0) && with_first, w == ways - 1);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		int target;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_writeback(2'd0, 4'd0);
		send_writeback(2'd0, 4'd0);
		send_writeback(2'd3, 4'd15);
		send_beat(bavs_pkg::CMD_NONE, 2'd3, 4'd15, 1'b1, 4'd15, 5'h0f, 1'b1, 1'b1);
		// dirty initial way on a written bank, steered to a free bank
		send_beat(bavs_pkg::CMD_VICTIM, 2'd0, 4'd0, 1'b1, 4'd15, 5'd1, 1'b1, 1'b0);
		send_beat(bavs_pkg::CMD_VICTIM, 2'd0, 4'd0, 1'b1, 4'd0, 5'd0, 1'b0, 1'b0);
		send_beat(bavs_pkg::CMD_VICTIM, 2'd1, 4'd5, 1'b1, 4'd7, 5'd0, 1'b0, 1'b1);
		// position tie, first candidate wins
		send_beat(bavs_pkg::CMD_EAGER, 2'd2, 4'd3, 1'b1, 4'd15, 5'h10, 1'b1, 1'b0);
		send_beat(bavs_pkg::CMD_EAGER, 2'd2, 4'd4, 1'b1, 4'd15, 5'h1f, 1'b0, 1'b1);
		// no initial victim, no candidate
		send_beat(bavs_pkg::CMD_VICTIM, 2'd1, 4'd1, 1'b0, 4'd0, 5'h1f, 1'b1, 1'b1);
		// initial way never scanned is kept
		send_beat(bavs_pkg::CMD_VICTIM, 2'd3, 4'd15, 1'b1, 4'd3, 5'd15, 1'b1, 1'b0);
		send_beat(bavs_pkg::CMD_VICTIM, 2'd2, 4'd8, 1'b1, 4'd9, 5'd0, 1'b0, 1'b1);
		send_beat(bavs_pkg::CMD_EAGER, 2'd0, 4'd2, 1'b0, 4'd0, 5'd0, 1'b1, 1'b1);
		// scan continuing from held state
		send_beat(bavs_pkg::CMD_VICTIM, 2'd1, 4'd6, 1'b1, 4'd1, 5'd0, 1'b0, 1'b1);
		settle();

		// back pressure: results held off while writebacks keep coming
		src_idle_pct = 0;
		hold_req <= 1'b1;
		repeat (40) send_writeback(2'($urandom_range(3)), 4'($urandom_range(15)));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(bavs_pkg::REG_POLICY_MODE, mode_plan[p]);
			write_reg(bavs_pkg::REG_PREFER_LOWER, {1'($urandom_range(1)), lower_plan[p]});
			cfg_valid <= 1'b0;
			src_idle_pct = (p == 3) ? 0 : 20;
			sink_idle_pct <= (p == 3) ? 0 : 20;
			target = items_sent + PHASE_BEATS;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 35)
					send_writeback(2'($urandom_range(3)), 4'($urandom_range(15)));
				else if (pick < 70)
					run_scan(bavs_pkg::CMD_VICTIM);
				else if (pick < 90)
					run_scan(bavs_pkg::CMD_EAGER);
				else
					send_beat(2'($urandom_range(3)), 2'($urandom_range(3)),
						4'($urandom_range(15)), 1'($urandom_range(1)), 4'($urandom_range(15)),
						5'($urandom_range(31)), 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
			settle();
		end

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bavs_pkg.sv
rtl/bavs_front.sv
rtl/bavs_queue.sv
rtl/bavs_back.sv
rtl/bank_aware_dirty_victim_select.sv
dv/victim_select_checker.sv
dv/testbench.sv
